@@ sv/adtp_pkg.sv @@
// Shared constants, widths and a helper function for the ASCII decimal triplet parser.
`default_nettype none

package adtp_pkg;

    // Number format: fraction digits kept and values per group.
    localparam int FRACTION_DIGITS = 3;
    localparam int AXES            = 3;

    // Field widths of the byte stream and of one result.
    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 31;
    localparam int AXIS_W  = 2;
    localparam int TDATA_OUT_W = ((VALUE_W + 7) / 8) * 8;

    // Magnitude accumulator and saturation limit.
    localparam int MAG_W = 30;
    localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(999999999);
    localparam int ACC_W = MAG_W + 4;

    // Fraction digit counter and the scale factor 10^(FRACTION_DIGITS - count).
    localparam int FRAC_W  = $clog2(FRACTION_DIGITS + 1);
    localparam int SCALE_W = $clog2(10 ** FRACTION_DIGITS + 1);
    localparam int PROD_W  = MAG_W + SCALE_W;

    // ASCII digit range.
    localparam logic [BYTE_W-1:0] CHAR_ZERO = BYTE_W'(48);
    localparam logic [BYTE_W-1:0] CHAR_NINE = BYTE_W'(57);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_FEED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RETURN    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_POINT     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_MINUS     = CFG_IDX_W'(4);

    // Reset values of the character codes.
    localparam logic [BYTE_W-1:0] RST_LINE_FEED = BYTE_W'(10);
    localparam logic [BYTE_W-1:0] RST_SEPARATOR = BYTE_W'(44);
    localparam logic [BYTE_W-1:0] RST_RETURN    = BYTE_W'(13);
    localparam logic [BYTE_W-1:0] RST_POINT     = BYTE_W'(46);
    localparam logic [BYTE_W-1:0] RST_MINUS     = BYTE_W'(45);

    // Scale needed to bring a number with k fraction digits to thousandths.
    // The input is narrow, so this folds into a small constant table.
    function automatic logic [SCALE_W-1:0] scale_factor(input logic [FRAC_W-1:0] k);
        logic [SCALE_W-1:0] r;
        r = SCALE_W'(1);
        for (int i = 0; i < FRACTION_DIGITS; i++) begin
            if (i >= int'(k)) begin
                r = SCALE_W'(r * SCALE_W'(10));
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/ascii_decimal_triplet_parser.sv @@
// Top level of the ASCII decimal triplet parser: byte stream in, signed thousandths out.
//
//  Channel  | Direction | Payload                              | Handshake
//  ---------+-----------+--------------------------------------+---------------------
//  s stream | in        | tdata = rx_byte                      | i_s_tvalid/o_s_tready
//  m stream | out       | tdata = value_milli, tuser = axis,   | o_m_tvalid/i_m_tready
//           |           | tlast = last                         |
//  cfg      | in        | index and 8-bit code                 | i_cfg_valid/o_cfg_ready
//
// One byte is accepted every cycle unless the input side stalls; each byte is held in the
// input register, which feeds one pass of logic (multiply by ten for digits, scale by a
// power of ten for terminators) that updates the number state and, for a terminator,
// loads the output register. A stall on a full output register holds the input register;
// the input side stalls only when both registers are full and the sink is not ready.
// Reset is synchronous, active low, and restores the default codes.
`default_nettype none

module ascii_decimal_triplet_parser (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input stream; tdata bits [7:0] = rx_byte.
    input  wire logic                               i_s_tvalid,
    output      logic                               o_s_tready,
    input  wire logic [adtp_pkg::BYTE_W-1:0]        i_s_tdata,
    // Output stream; tdata bits [30:0] = value_milli, bit [31] = 0.
    output      logic                               o_m_tvalid,
    input  wire logic                               i_m_tready,
    output      logic [adtp_pkg::TDATA_OUT_W-1:0]   o_m_tdata,
    // tuser bits [1:0] = axis.
    output      logic [adtp_pkg::AXIS_W-1:0]        o_m_tuser,
    output      logic                               o_m_tlast,
    // Configuration write channel.
    input  wire logic                               i_cfg_valid,
    output      logic                               o_cfg_ready,
    input  wire logic [adtp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [adtp_pkg::BYTE_W-1:0]        i_cfg_data
);

    // Input register.
    logic                          r_in_valid;
    logic [adtp_pkg::BYTE_W-1:0]   r_in_byte;

    // Character code registers.
    logic [adtp_pkg::BYTE_W-1:0]   r_lf_code, r_sep_code, r_ret_code, r_pt_code, r_minus_code;

    // Number state.
    logic [adtp_pkg::MAG_W-1:0]    r_mag, n_mag;
    logic [adtp_pkg::FRAC_W-1:0]   r_frac_cnt, n_frac_cnt;
    logic                          r_point, n_point;
    logic                          r_neg, n_neg;
    logic [adtp_pkg::AXIS_W-1:0]   r_axis, n_axis;

    // Output register.
    logic                                 r_out_valid, n_out_valid;
    logic signed [adtp_pkg::VALUE_W-1:0]  r_out_value, n_out_value;
    logic [adtp_pkg::AXIS_W-1:0]          r_out_axis, n_out_axis;
    logic                                 r_out_last, n_out_last;

    // Datapath intermediates.
    logic                          w_advance;
    logic                          w_is_digit;
    logic [3:0]                    w_digit;
    logic [adtp_pkg::ACC_W-1:0]    w_acc;
    logic [adtp_pkg::FRAC_W-1:0]   w_frac_used;
    logic [adtp_pkg::SCALE_W-1:0]  w_scale;
    logic [adtp_pkg::PROD_W-1:0]   w_scaled;
    logic [adtp_pkg::MAG_W-1:0]    w_sat;
    logic [adtp_pkg::AXIS_W:0]     w_axis_next;
    logic [adtp_pkg::AXIS_W-1:0]   w_axis_cur;

    // The input register moves on whenever the output register is free or being drained.
    assign w_advance   = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    // Digit accumulate: magnitude times ten plus the digit, saturated.
    assign w_is_digit = (r_in_byte >= adtp_pkg::CHAR_ZERO) && (r_in_byte <= adtp_pkg::CHAR_NINE);
    assign w_digit    = 4'(r_in_byte - adtp_pkg::CHAR_ZERO);
    assign w_acc      = (adtp_pkg::ACC_W'(r_mag) << 3) + (adtp_pkg::ACC_W'(r_mag) << 1)
                        + adtp_pkg::ACC_W'(w_digit);

    // Terminator scaling to thousandths, saturated.
    assign w_frac_used = r_point ? r_frac_cnt : '0;
    assign w_scale     = adtp_pkg::scale_factor(w_frac_used);
    assign w_scaled    = adtp_pkg::PROD_W'(r_mag) * adtp_pkg::PROD_W'(w_scale);
    assign w_sat       = (w_scaled > adtp_pkg::PROD_W'(adtp_pkg::MAG_MAX))
                         ? adtp_pkg::MAG_MAX : w_scaled[adtp_pkg::MAG_W-1:0];

    // Axis of this value and its successor.
    assign w_axis_cur  = (int'(r_axis) < adtp_pkg::AXES) ? r_axis : '0;
    assign w_axis_next = {1'b0, w_axis_cur} + (adtp_pkg::AXIS_W+1)'(1);

    // Byte classification and next state; the first matching code wins.
    always_comb begin
        n_mag       = r_mag;
        n_frac_cnt  = r_frac_cnt;
        n_point     = r_point;
        n_neg       = r_neg;
        n_axis      = r_axis;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_value = r_out_value;
        n_out_axis  = r_out_axis;
        n_out_last  = r_out_last;
        if (w_advance) begin
            priority if (r_in_byte == r_lf_code || r_in_byte == r_sep_code) begin
                n_out_valid = 1'b1;
                n_out_value = r_neg ? -$signed(adtp_pkg::VALUE_W'(w_sat))
                                    : $signed(adtp_pkg::VALUE_W'(w_sat));
                n_out_axis  = w_axis_cur;
                n_out_last  = int'(w_axis_next) >= adtp_pkg::AXES;
                n_axis      = (int'(w_axis_next) >= adtp_pkg::AXES)
                              ? '0 : w_axis_next[adtp_pkg::AXIS_W-1:0];
                n_mag       = '0;
                n_frac_cnt  = '0;
                n_point     = 1'b0;
                n_neg       = 1'b0;
            end else if (r_in_byte == r_ret_code) begin
                n_mag = r_mag;
            end else if (r_in_byte == r_pt_code) begin
                n_point = 1'b1;
            end else if (r_in_byte == r_minus_code) begin
                n_neg = 1'b1;
            end else if (w_is_digit) begin
                // Fraction digits past the kept count are dropped.
                if (!r_point || int'(r_frac_cnt) < adtp_pkg::FRACTION_DIGITS) begin
                    if (r_point) begin
                        n_frac_cnt = r_frac_cnt + adtp_pkg::FRAC_W'(1);
                    end
                    n_mag = (w_acc > adtp_pkg::ACC_W'(adtp_pkg::MAG_MAX))
                            ? adtp_pkg::MAG_MAX : w_acc[adtp_pkg::MAG_W-1:0];
                end
            end
        end
    end

    // Control state, number state and code registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_mag        <= '0;
            r_frac_cnt   <= '0;
            r_point      <= 1'b0;
            r_neg        <= 1'b0;
            r_axis       <= '0;
            r_lf_code    <= adtp_pkg::RST_LINE_FEED;
            r_sep_code   <= adtp_pkg::RST_SEPARATOR;
            r_ret_code   <= adtp_pkg::RST_RETURN;
            r_pt_code    <= adtp_pkg::RST_POINT;
            r_minus_code <= adtp_pkg::RST_MINUS;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            r_out_valid <= n_out_valid;
            r_mag       <= n_mag;
            r_frac_cnt  <= n_frac_cnt;
            r_point     <= n_point;
            r_neg       <= n_neg;
            r_axis      <= n_axis;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    adtp_pkg::CFG_LINE_FEED: r_lf_code    <= i_cfg_data;
                    adtp_pkg::CFG_SEPARATOR: r_sep_code   <= i_cfg_data;
                    adtp_pkg::CFG_RETURN:    r_ret_code   <= i_cfg_data;
                    adtp_pkg::CFG_POINT:     r_pt_code    <= i_cfg_data;
                    adtp_pkg::CFG_MINUS:     r_minus_code <= i_cfg_data;
                    default:                 r_lf_code    <= r_lf_code;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        r_out_value <= n_out_value;
        r_out_axis  <= n_out_axis;
        r_out_last  <= n_out_last;
    end

    // Output ports.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = adtp_pkg::TDATA_OUT_W'(unsigned'(r_out_value));
    assign o_m_tuser  = r_out_axis;
    assign o_m_tlast  = r_out_last;

    // The axis counter and the emitted axis always stay within the group.
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_axis) < adtp_pkg::AXES && (!r_out_valid || int'(r_out_axis) < adtp_pkg::AXES))
        else $error("axis index out of range");

    // The last flag marks exactly the final axis of a group.
    a_last_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == (int'(r_out_axis) == adtp_pkg::AXES - 1)))
        else $error("last flag does not match axis");

    // The magnitude never passes its saturation limit and the fraction count its maximum.
    a_state_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mag <= adtp_pkg::MAG_MAX && int'(r_frac_cnt) <= adtp_pkg::FRACTION_DIGITS)
        else $error("number state out of range");

    // A held result with a stalled sink blocks the input register from advancing.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready && r_in_valid) |=> r_in_valid && $stable(r_in_byte))
        else $error("input request lost during output stall");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the ASCII decimal triplet parser: text bytes in, thousandths out.
`default_nettype none

module tb;
    import adtp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES = 6;
    localparam int REPORT_LINES = 50;
    // Index past the last register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(7);

    // One result of the parser as it should appear on the output stream.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [AXIS_W-1:0]  axis;
        logic               last;
    } t_milli_result;

    logic clk;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic [BYTE_W-1:0]     s_tdata = '0;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [BYTE_W-1:0]     cfg_data = '0;

    wire                   o_s_tready;
    wire                   o_m_tvalid;
    wire [TDATA_OUT_W-1:0] o_m_tdata;
    wire [AXIS_W-1:0]      o_m_tuser;
    wire                   o_m_tlast;
    wire                   o_cfg_ready;

    // Bytes waiting to be offered, and results the parser still owes.
    logic [BYTE_W-1:0] text_bytes [$];
    t_milli_result     owed_values [$];
    int                bytes_queued = 0;
    int                mismatch_count = 0;

    // Traffic shaping shared between the sequencer and the two stream sides.
    logic idle_enable = 1'b0;
    int   hold_ask = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   src_gap = 0;
    int   sink_gap = 0;
    int   stall_cycles = 0;

    // Predicted character codes and number state.
    logic [BYTE_W-1:0] lf_code  = RST_LINE_FEED;
    logic [BYTE_W-1:0] sep_code = RST_SEPARATOR;
    logic [BYTE_W-1:0] ret_code = RST_RETURN;
    logic [BYTE_W-1:0] pt_code  = RST_POINT;
    logic [BYTE_W-1:0] mn_code  = RST_MINUS;
    logic [33:0]       magnitude_acc = '0;
    int                frac_digits = 0;
    logic              point_seen = 1'b0;
    logic              negative = 1'b0;
    logic [AXIS_W-1:0] axis_next = '0;
    t_milli_result     head_value;

    ascii_decimal_triplet_parser i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Multiply by ten and add a digit, saturating at the largest magnitude.
    function automatic logic [33:0] ten_times_plus(input logic [33:0] m, input logic [3:0] d);
        logic [33:0] r;
        r = m * 34'd10 + 34'(d);
        return (r > 34'(MAG_MAX)) ? 34'(MAG_MAX) : r;
    endfunction

    // Advance the number state by one accepted byte; a terminator owes one result.
    task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
        logic [33:0]   v;
        int            k;
        t_milli_result r;
        if (b == lf_code || b == sep_code) begin
            v = magnitude_acc;
            k = point_seen ? frac_digits : 0;
            while (k < FRACTION_DIGITS) begin
                v = ten_times_plus(v, 4'd0);
                k++;
            end
            r.value = negative ? VALUE_W'(34'd0 - v) : VALUE_W'(v);
            r.axis = axis_next;
            r.last = (int'(axis_next) == AXES - 1);
            owed_values.push_back(r);
            axis_next = r.last ? '0 : axis_next + AXIS_W'(1);
            magnitude_acc = '0;
            frac_digits = 0;
            point_seen = 1'b0;
            negative = 1'b0;
        end else if (b == ret_code) begin
            // Carriage returns are dropped.
        end else if (b == pt_code) begin
            point_seen = 1'b1;
        end else if (b == mn_code) begin
            negative = 1'b1;
        end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            // Fraction digits past the kept precision are dropped.
            if (!point_seen || frac_digits < FRACTION_DIGITS) begin
                if (point_seen) begin
                    frac_digits++;
                end
                magnitude_acc = ten_times_plus(magnitude_acc, 4'(b - CHAR_ZERO));
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES) begin
            $display("mismatch in %s at %0t: got 0x%08h, expected 0x%08h",
                     what, $time, got, want);
        end
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        text_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i]);
        end
    endtask

    task automatic push_digits(input int n);
        repeat (n) push_byte(BYTE_W'(CHAR_ZERO + $urandom_range(0, 9)));
    endtask

    // One number in the current codes: mostly well formed, sometimes garbled.
    task automatic queue_number();
        int shape;
        int n_int;
        shape = $urandom_range(0, 19);
        if (shape == 0) begin
            // Pure noise ending in a terminator.
            repeat ($urandom_range(1, 6)) push_byte(BYTE_W'($urandom_range(0, 255)));
            push_byte($urandom_range(0, 1) ? lf_code : sep_code);
        end else begin
            if ($urandom_range(0, 11) == 0) begin
                push_byte(BYTE_W'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 2) == 0) begin
                push_byte(mn_code);
            end
            shape = $urandom_range(0, 15);
            n_int = (shape == 0) ? 0 :
                    (shape < 12) ? $urandom_range(1, 3) :
                    (shape < 14) ? $urandom_range(4, 7) : $urandom_range(8, 12);
            push_digits(n_int);
            if ($urandom_range(0, 9) == 0) begin
                push_byte(ret_code);
            end
            if ($urandom_range(0, 2) != 0) begin
                push_byte(pt_code);
                push_digits(($urandom_range(0, 4) == 0) ? $urandom_range(4, 6)
                                                        : $urandom_range(0, 3));
                if ($urandom_range(0, 9) == 0) begin
                    push_byte(pt_code);
                    push_digits($urandom_range(0, 2));
                end
            end
            if ($urandom_range(0, 11) == 0) begin
                push_byte(mn_code);
            end
            push_byte($urandom_range(0, 1) ? lf_code : sep_code);
        end
    endtask

    task automatic queue_random(input int count);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < count) begin
            queue_number();
        end
    endtask

    // Wait until every byte is taken and every result has come back, then let the
    // pipeline empty of bytes that owe nothing.
    task automatic wait_for_drain();
        do @(posedge clk);
        while (text_bytes.size() != 0 || s_tvalid || owed_values.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all five codes, optionally touching the unused index too.
    task automatic program_codes(input logic [BYTE_W-1:0] lf, sep, ret, pt, mn,
                                 input bit touch_spare);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [BYTE_W-1:0]    val [6];
        int                   n;
        idx[0] = CFG_LINE_FEED; val[0] = lf;
        idx[1] = CFG_SEPARATOR; val[1] = sep;
        idx[2] = CFG_RETURN;    val[2] = ret;
        idx[3] = CFG_POINT;     val[3] = pt;
        idx[4] = CFG_MINUS;     val[4] = mn;
        idx[5] = CFG_SPARE;     val[5] = 8'hA5;
        n = touch_spare ? 6 : 5;
        for (int i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            while (!o_cfg_ready) @(posedge clk);
            case (idx[i])
                CFG_LINE_FEED: lf_code = val[i];
                CFG_SEPARATOR: sep_code = val[i];
                CFG_RETURN:    ret_code = val[i];
                CFG_POINT:     pt_code = val[i];
                CFG_MINUS:     mn_code = val[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Sender: offers queued bytes, with random gaps, and predicts on each request.
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                parse_rx_byte(s_tdata);
            end
            if (!(s_tvalid && !o_s_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (idle_enable && $urandom_range(0, 15) == 0) begin
                    src_gap = $urandom_range(0, 10);
                    s_tvalid <= 1'b0;
                end else if (text_bytes.size() != 0) begin
                    s_tdata <= text_bytes.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result against the oldest owed value, with random stalls
    // and one long hold-off on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (owed_values.size() == 0) begin
                    report_mismatch("unexpected result", o_m_tdata, 32'd0);
                end else begin
                    head_value = owed_values.pop_front();
                    if (o_m_tdata !== TDATA_OUT_W'(head_value.value)) begin
                        report_mismatch("value_milli", o_m_tdata, 32'(head_value.value));
                    end
                    if (o_m_tuser !== head_value.axis) begin
                        report_mismatch("axis", 32'(o_m_tuser), 32'(head_value.axis));
                    end
                    if (o_m_tlast !== head_value.last) begin
                        report_mismatch("last", 32'(o_m_tlast), 32'(head_value.last));
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = HOLD_OFF_CYCLES;
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 15) == 0) begin
                sink_gap = $urandom_range(0, 10);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no channel moves for too long.
    always @(posedge clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) ||
            (cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sequencer: reset, then phases of text under different code settings.
    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_enable <= 1'b1;

        // Directed text under the reset codes: empty number, minus zero, extra
        // fraction digits, carriage return with a repeated point, a trailing minus
        // and a stray byte, then a whole number that saturates once scaled.
        push_text(",");
        push_text("-0\n");
        push_text("1.2345,");
        push_text("2");
        push_byte(RST_RETURN);
        push_text(".5.5-");
        push_byte(8'hFF);
        push_text("\n");
        push_text("1000");
        push_byte(8'h00);
        push_text("000,");
        queue_random(520);
        wait_for_drain();

        // Extreme codes; the receiver holds off while the sender keeps going.
        program_codes(8'h00, 8'hFF, 8'h7F, 8'h2C, 8'h3B, 1'b1);
        hold_ask <= hold_ask + 1;
        queue_random(460);
        wait_for_drain();

        // Overlapping codes, where priority decides, and a digit used as minus.
        program_codes(8'h0A, 8'h0A, 8'h2E, 8'h2E, 8'h37, 1'b0);
        queue_random(460);
        wait_for_drain();

        // Back to the usual codes at full rate.
        program_codes(RST_LINE_FEED, RST_SEPARATOR, RST_RETURN, RST_POINT, RST_MINUS, 1'b0);
        idle_enable <= 1'b0;
        queue_random(480);
        wait_for_drain();

        if (mismatch_count == 0 && owed_values.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
